// ===== design/lbmc_pkg.sv =====
// Shared types, register indexes and blend mode codes of the layer compositor.
`timescale 1ns / 1ps

package lbmc_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_BLEND_MODE      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_USE_OPACITY     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OPACITY         = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD_DEST_ALPHA = 2'd3;

	localparam logic [2:0] MODE_ALPHA      = 3'd0;
	localparam logic [2:0] MODE_ADD        = 3'd1;
	localparam logic [2:0] MODE_BURN       = 3'd2;
	localparam logic [2:0] MODE_MULTIPLY   = 3'd3;
	localparam logic [2:0] MODE_SCREEN     = 3'd4;
	localparam logic [2:0] MODE_LIGHTEN    = 3'd5;
	localparam logic [2:0] MODE_DARKEN     = 3'd6;
	localparam logic [2:0] MODE_DIFFERENCE = 3'd7;

	localparam logic [7:0] OPACITY_RESET = 8'hff;

	localparam int LBMC_QUEUE_DEPTH = 2;

	// One classified pixel as it travels from the front part to the back part.
	typedef struct packed {
		logic [23:0] src_rgb;
		logic [23:0] dst_rgb;
		logic [7:0]  alpha;
		logic [7:0]  out_alpha;
		logic [2:0]  mode;
		logic        span_end;
	} lbmc_word_t;

endpackage

// ===== design/lbmc_if.sv =====
// Valid/ready channel interfaces for input and result pixels.
`timescale 1ns / 1ps

interface lbmc_pix_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_color;
	logic [31:0] dst_color;
	logic        span_end;

	modport source(output valid, output src_color, output dst_color, output span_end,
		input ready);
	modport sink(input valid, input src_color, input dst_color, input span_end,
		output ready);
endinterface

interface lbmc_pix_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_color;
	logic        span_end_out;

	modport source(output valid, output out_color, output span_end_out, input ready);
	modport sink(input valid, input out_color, input span_end_out, output ready);
endinterface

// ===== design/lbmc_front.sv =====
// Front part: configuration registers, pixel intake and effective alpha.
`timescale 1ns / 1ps

module lbmc_front import lbmc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	lbmc_pix_in_if.sink            pix_in,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output lbmc_word_t             word,
	output logic                   word_valid,
	input  logic                   word_ready
);

	logic [2:0]  mode_q;
	logic        use_opacity_q;
	logic [7:0]  opacity_q;
	logic        hold_q;

	logic        valid_s1;
	lbmc_word_t  word_s1;
	logic [15:0] scaled;
	logic [7:0]  alpha_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_ALPHA;
			use_opacity_q <= 1'b0;
			opacity_q     <= OPACITY_RESET;
			hold_q        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLEND_MODE:      mode_q        <= cfg_data[2:0];
				REG_USE_OPACITY:     use_opacity_q <= cfg_data[0];
				REG_OPACITY:         opacity_q     <= cfg_data[7:0];
				REG_HOLD_DEST_ALPHA: hold_q        <= cfg_data[0];
			endcase
		end
	end

	assign scaled    = pix_in.src_color[31:24] * opacity_q;
	assign alpha_eff = use_opacity_q ? scaled[15:8] : pix_in.src_color[31:24];

	assign pix_in.ready = !valid_s1 || word_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.ready && pix_in.valid) begin
			word_s1.src_rgb   <= pix_in.src_color[23:0];
			word_s1.dst_rgb   <= pix_in.dst_color[23:0];
			word_s1.alpha     <= alpha_eff;
			word_s1.out_alpha <= hold_q ? pix_in.dst_color[31:24] : 8'd0;
			word_s1.mode      <= mode_q;
			word_s1.span_end  <= pix_in.span_end;
		end
	end

	assign word       = word_s1;
	assign word_valid = valid_s1;

endmodule

// ===== design/lbmc_fifo.sv =====
// Short word queue between the front and back parts.
`timescale 1ns / 1ps

module lbmc_fifo import lbmc_pkg::*; #(
	parameter int DEPTH = LBMC_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lbmc_word_t push_word,
	input  logic       push_valid,
	output logic       push_ready,
	output lbmc_word_t pop_word,
	output logic       pop_valid,
	input  logic       pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	lbmc_word_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_word   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/lbmc_back.sv =====
// Back part: per-channel blend, alpha mix and the output register.
`timescale 1ns / 1ps

module lbmc_back import lbmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lbmc_word_t word,
	input  logic       word_valid,
	output logic       word_ready,
	lbmc_pix_out_if.source pix_out
);

	// Blend color for every mode except screen, which is handled on its own.
	function automatic logic [7:0] blend_color(input logic [2:0] mode, input logic [7:0] d,
		input logic [7:0] s, input logic [15:0] prod);
		logic [8:0] sum;
		logic [8:0] burn;
		logic [7:0] b;
		sum  = {1'b0, d} + {1'b0, s};
		burn = sum - 9'd255;
		unique case (mode)
			MODE_ALPHA:      b = s;
			MODE_ADD:        b = sum[8] ? 8'hff : sum[7:0];
			MODE_BURN:       b = sum[8] ? burn[7:0] : 8'd0;
			MODE_MULTIPLY:   b = prod[15:8];
			MODE_SCREEN:     b = s;
			MODE_LIGHTEN:    b = (d > s) ? d : s;
			MODE_DARKEN:     b = (d < s) ? d : s;
			MODE_DIFFERENCE: b = (d > s) ? (d - s) : (s - d);
		endcase
		return b;
	endfunction

	logic              v_s1;
	lbmc_word_t        word_s1;
	logic [15:0]       prod_s1 [3];

	logic              v_s2;
	logic [23:0]       dst_s2;
	logic [7:0]        out_alpha_s2;
	logic              span_s2;
	logic signed [17:0] mix_s2 [3];

	logic              v_s3;
	logic [31:0]       color_s3;
	logic              span_s3;

	logic              rdy_s1;
	logic              rdy_s2;
	logic              rdy_s3;

	logic [15:0]       prod   [3];
	logic signed [8:0] diff   [3];
	logic signed [17:0] mix   [3];
	logic signed [17:0] total [3];
	logic [7:0]        chan   [3];

	// A stage moves on when it is empty or its successor moves on.
	assign rdy_s3     = !v_s3 || pix_out.ready;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign word_ready = rdy_s1;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c] = word.dst_rgb[8*c +: 8] * word.src_rgb[8*c +: 8];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (word_s1.mode == MODE_SCREEN) begin
				diff[c] = $signed({1'b0, word_s1.src_rgb[8*c +: 8]})
					- $signed({1'b0, prod_s1[c][15:8]});
			end else begin
				diff[c] = $signed({1'b0, blend_color(word_s1.mode, word_s1.dst_rgb[8*c +: 8],
					word_s1.src_rgb[8*c +: 8], prod_s1[c])})
					- $signed({1'b0, word_s1.dst_rgb[8*c +: 8]});
			end
			mix[c] = diff[c] * $signed({1'b0, word_s1.alpha});
		end
	end

	// Arithmetic shift floors the signed mix; only screen can pass 255.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			total[c] = $signed({10'd0, dst_s2[8*c +: 8]}) + (mix_s2[c] >>> 8);
			chan[c]  = (total[c] > 18'sd255) ? 8'hff : total[c][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= word_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && word_valid) begin
			word_s1 <= word;
			for (int c = 0; c < 3; c++) begin
				prod_s1[c] <= prod[c];
			end
		end
		if (rdy_s2 && v_s1) begin
			dst_s2       <= word_s1.dst_rgb;
			out_alpha_s2 <= word_s1.out_alpha;
			span_s2      <= word_s1.span_end;
			for (int c = 0; c < 3; c++) begin
				mix_s2[c] <= mix[c];
			end
		end
		if (rdy_s3 && v_s2) begin
			color_s3 <= {out_alpha_s2, chan[2], chan[1], chan[0]};
			span_s3  <= span_s2;
		end
	end

	assign pix_out.valid        = v_s3;
	assign pix_out.out_color    = color_s3;
	assign pix_out.span_end_out = span_s3;

endmodule

// ===== design/layer_blend_mode_compositor_unit.sv =====
// Top level of the layer blend mode compositor: front part, queue and back part.
//
//  channel    dir  word                                   handshake
//  pix_in     in   src_color, dst_color, span_end         valid/ready
//  pix_out    out  out_color, span_end_out                valid/ready
//  cfg        in   cfg_index, cfg_data                    cfg_we, no wait
//
// One pixel word is accepted per clock while pix_in.ready is high; a word taken into the
// front stage passes the queue and the three back stages before it is valid on pix_out.
// Reset clears all valid state and the queue, and puts the registers at their
// reset values (mode alpha, opacity 255, opacity and alpha hold off).
// When pix_out stalls, the back stages fill first, then the queue and the front stage,
// and only then does pix_in.ready fall.
`timescale 1ns / 1ps

module layer_blend_mode_compositor_unit import lbmc_pkg::*; #(
	parameter int QUEUE_DEPTH = LBMC_QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	lbmc_pix_in_if.sink            pix_in,
	lbmc_pix_out_if.source         pix_out,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	lbmc_word_t front_word;
	logic       front_valid;
	logic       front_ready;
	lbmc_word_t back_word;
	logic       back_valid;
	logic       back_ready;

	lbmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_in     (pix_in),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.word       (front_word),
		.word_valid (front_valid),
		.word_ready (front_ready)
	);

	lbmc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_word  (front_word),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_word   (back_word),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	lbmc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word       (back_word),
		.word_valid (back_valid),
		.word_ready (back_ready),
		.pix_out    (pix_out)
	);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of the layer blend mode compositor.
`timescale 1ns / 1ps

module tb_top;
	import lbmc_pkg::*;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lbmc_pix_in_if pix_in();
	lbmc_pix_out_if pix_out();

	layer_blend_mode_compositor_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_in(pix_in),
		.pix_out(pix_out),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Holds the expected composited pixels and a private copy of the registers.
	class blend_scoreboard;
		typedef struct {
			logic [31:0] color;
			logic        span_end;
		} pixel_result_t;

		pixel_result_t expected_pixels[$];
		logic [2:0] mode;
		logic       use_opacity;
		logic [7:0] opacity;
		logic       hold_alpha;
		int         errors;
		int         checked;

		function new();
			mode = MODE_ALPHA;
			use_opacity = 1'b0;
			opacity = OPACITY_RESET;
			hold_alpha = 1'b0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_BLEND_MODE: mode = data[2:0];
				REG_USE_OPACITY: use_opacity = data[0];
				REG_OPACITY: opacity = data;
				REG_HOLD_DEST_ALPHA: hold_alpha = data[0];
				default: ;
			endcase
		endfunction

		// Moves d toward b by a/256, rounding toward minus infinity.
		function int mix_channel(int d, int b, int a);
			if (b >= d)
				return d + (((b - d) * a) >> 8);
			return d - ((((d - b) * a) + 255) >> 8);
		endfunction

		function logic [7:0] blend_channel(int d, int s, int a);
			int b;
			int t;
			case (mode)
				MODE_ALPHA: b = s;
				MODE_ADD: b = (d + s > 255) ? 255 : d + s;
				MODE_BURN: b = (d + s > 255) ? d + s - 255 : 0;
				MODE_MULTIPLY: b = (d * s) >> 8;
				MODE_SCREEN: begin
					t = d + (((s - ((d * s) >> 8)) * a) >> 8);
					return (t > 255) ? 8'hff : 8'(t);
				end
				MODE_LIGHTEN: b = (d > s) ? d : s;
				MODE_DARKEN: b = (d < s) ? d : s;
				default: b = (d > s) ? d - s : s - d;
			endcase
			return 8'(mix_channel(d, b, a));
		endfunction

		function void note_pixel(logic [31:0] src, logic [31:0] dst, logic span_end);
			pixel_result_t r;
			int a;
			a = src[31:24];
			if (use_opacity)
				a = (a * opacity) >> 8;
			r.color[31:24] = hold_alpha ? dst[31:24] : 8'h00;
			for (int sh = 0; sh < 24; sh += 8)
				r.color[sh +: 8] = blend_channel(dst[sh +: 8], src[sh +: 8], a);
			r.span_end = span_end;
			expected_pixels.push_back(r);
		endfunction

		function void check_pixel(logic [31:0] color, logic span_end);
			pixel_result_t e;
			if (expected_pixels.size() == 0) begin
				$error("result word %h with no pixel outstanding", color);
				errors++;
				return;
			end
			e = expected_pixels.pop_front();
			checked++;
			if (color !== e.color) begin
				$error("out_color: expected %h, actual %h", e.color, color);
				errors++;
			end
			if (span_end !== e.span_end) begin
				$error("span_end_out: expected %b, actual %b", e.span_end, span_end);
				errors++;
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	blend_scoreboard sb;
	int src_idle_pct;
	int snk_idle_pct;
	int src_burst;
	int settings_used;

	always #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Result side: sample at the rising edge, move ready at the falling edge.
	initial begin
		int snk_burst;
		snk_burst = 0;
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (pix_out.valid && pix_out.ready)
				sb.check_pixel(pix_out.out_color, pix_out.span_end_out);
			@(negedge clk);
			if (snk_burst > 0)
				snk_burst--;
			else if ($urandom_range(31) == 0)
				snk_burst = $urandom_range(40, 10);
			pix_out.ready <= (snk_burst > 0) || ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic send_pixel(logic [31:0] src, logic [31:0] dst, logic span_end);
		@(negedge clk);
		if (src_burst > 0)
			src_burst--;
		else begin
			while ($urandom_range(99) < src_idle_pct) begin
				pix_in.valid <= 1'b0;
				@(negedge clk);
			end
		end
		pix_in.valid <= 1'b1;
		pix_in.src_color <= src;
		pix_in.dst_color <= dst;
		pix_in.span_end <= span_end;
		@(posedge clk);
		while (!pix_in.ready)
			@(posedge clk);
		sb.note_pixel(src, dst, span_end);
	endtask

	// Stop sending and let every outstanding word come back.
	task automatic drain();
		@(negedge clk);
		pix_in.valid <= 1'b0;
		while (sb.pending() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Upper register bits carry junk; the block must ignore them.
	task automatic apply_setting(logic [2:0] mode, logic use_op, logic [7:0] opac,
		logic hold);
		write_reg(REG_BLEND_MODE, {5'($urandom), mode});
		write_reg(REG_USE_OPACITY, {7'($urandom), use_op});
		write_reg(REG_OPACITY, opac);
		write_reg(REG_HOLD_DEST_ALPHA, {7'($urandom), hold});
		settings_used++;
	endtask

	task automatic send_random_pixel();
		logic [31:0] src;
		logic [31:0] dst;
		src = $urandom;
		dst = $urandom;
		case ($urandom_range(9))
			0: src[31:24] = 8'h00;
			1: src[31:24] = 8'hff;
			default: ;
		endcase
		if ($urandom_range(7) == 0)
			dst[23:0] = src[23:0];
		if ($urandom_range(9) == 0)
			dst[23:0] = {3{8'hff}};
		send_pixel(src, dst, $urandom_range(7) == 0);
	endtask

	initial begin
		logic [2:0] m;
		logic [7:0] opac;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_in.valid = 1'b0;
		pix_in.src_color = '0;
		pix_in.dst_color = '0;
		pix_in.span_end = 1'b0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		src_burst = 0;
		settings_used = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings first, then every mode against the channel extremes.
		send_pixel(32'hff80c0ff, 32'h12345678, 1'b1);
		drain();
		for (int k = 0; k < 8; k++) begin
			m = 3'(k);
			apply_setting(m, m[1], m[2] ? 8'h00 : 8'h80, m[0]);
			send_pixel(32'hffffffff, 32'h00000000, 1'b1);
			send_pixel(32'h00ffffff, 32'h80a5c3ff, 1'b0);
			send_pixel(32'hffffff00, 32'hff00ffff, 1'b1);
			drain();
		end

		for (int p = 0; p < 3; p++) begin
			src_idle_pct = (p == 0) ? 22 : (p == 1) ? 66 : 0;
			snk_idle_pct = (p == 0) ? 66 : (p == 1) ? 22 : 0;
			for (int k = 0; k < 8; k++) begin
				case ($urandom_range(3))
					0: opac = 8'h00;
					1: opac = 8'hff;
					default: opac = 8'($urandom);
				endcase
				apply_setting(3'(k + 3 * p), 1'($urandom), opac, 1'($urandom));
				for (int n = 0; n < 50; n++) begin
					if (src_idle_pct > 0 && $urandom_range(15) == 0)
						src_burst = $urandom_range(30, 8);
					send_random_pixel();
				end
				drain();
			end
		end

		$display("Checked %0d composited pixels under %0d register settings.",
			sb.checked, settings_used);
		$display("All eight blend modes ran with opacity scaling and alpha hold both ways.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
